### hdl/lzps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzps_pkg
// shared types, constants and helpers for the lz78 pair stream parser
// ----------------------------------------------------------------------------
package lzps_pkg;

    // longest index sequence taken, lead byte included (range 1 to 4)
    localparam int MAX_SEQ_LEN = 4;
    localparam logic [2:0] SEQ_LIMIT = 3'(MAX_SEQ_LEN);
    // longest sequence the lead byte coding can announce
    localparam logic [2:0] CODE_LIMIT = 3'd4;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 21;

    // input opcodes (carried on s_tuser)
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // special lengths returned by lead_len
    localparam logic [2:0] LEN_STRAY    = 3'd0;
    localparam logic [2:0] LEN_SINGLE   = 3'd1;
    localparam logic [2:0] LEN_OVERLONG = 3'd5;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] END_CHAR  = 8'h7E;

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_CONT = 3'b010,
        PH_CHAR = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [2:0]         expected;
        logic [2:0]         seen;
        logic [INDEX_W-1:0] acc;
    } parse_state_t;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  pchar;
        logic               term;
    } pair_t;

    localparam parse_state_t STATE_RESET = '{
        phase:    PH_LEAD,
        expected: 3'd0,
        seen:     3'd0,
        acc:      '0
    };

    // sequence length announced by a lead byte
    function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [2:0] n;
        if (b < 8'h80)
            n = LEN_SINGLE;
        else if (b < 8'hC0)
            n = LEN_STRAY;
        else if (b <= 8'hDF)
            n = 3'd2;
        else if (b <= 8'hEF)
            n = 3'd3;
        else if (b <= 8'hF7)
            n = 3'd4;
        else
            n = LEN_OVERLONG;
        return n;
    endfunction

    // 6 * k for the payload bit position of a byte
    function automatic logic [4:0] six_times(input logic [2:0] k);
        return ({2'b00, k} << 2) + ({2'b00, k} << 1);
    endfunction

endpackage
`default_nettype wire

### hdl/lzps_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzps_step
// next parser state and emitted pair for one stream transaction
// ----------------------------------------------------------------------------
module lzps_step
(
    input  var lzps_pkg::parse_state_t cur,
    input  wire                        opcode,
    input  wire [7:0]                  byte_value,
    output lzps_pkg::parse_state_t     nxt,
    output lzps_pkg::pair_t            res
);

    logic [2:0]  lead_n;
    logic [7:0]  lead_mask;
    logic [4:0]  lead_shift;
    logic [20:0] lead_acc;
    logic [2:0]  seen_inc;
    logic [4:0]  cont_shift;
    logic [20:0] cont_acc;
    logic        cont_ok;

    always_comb
    begin
        lead_n     = lzps_pkg::lead_len(byte_value);
        lead_mask  = 8'h7F >> lead_n;
        lead_shift = lzps_pkg::six_times(lead_n - 3'd1);
        lead_acc   = {13'b0, byte_value & lead_mask} << lead_shift;
        seen_inc   = cur.seen + 3'd1;
        cont_shift = lzps_pkg::six_times(cur.expected - seen_inc);
        cont_acc   = {15'b0, byte_value[5:0]} << cont_shift;
        cont_ok    = ((byte_value & lzps_pkg::CONT_MASK) == lzps_pkg::CONT_TAG)
                     && (cur.seen < cur.expected)
                     && (cur.expected <= lzps_pkg::CODE_LIMIT);
    end

    always_comb
    begin
        nxt       = cur;
        res.valid = 1'b0;
        res.index = cur.acc;
        res.pchar = byte_value;
        res.term  = 1'b0;
        if (opcode == lzps_pkg::OP_EOS)
        begin
            nxt       = lzps_pkg::STATE_RESET;
            res.valid = 1'b1;
            res.index = '0;
            res.pchar = lzps_pkg::END_CHAR;
            res.term  = 1'b1;
        end
        else
        begin
            unique case (cur.phase)
                lzps_pkg::PH_CONT:
                begin
                    if (cont_ok)
                    begin
                        nxt.seen = seen_inc;
                        nxt.acc  = cur.acc | cont_acc;
                        if (seen_inc == cur.expected)
                            nxt.phase = lzps_pkg::PH_CHAR;
                    end
                    else
                    begin
                        // truncated sequence: byte dropped, missing bits stay zero
                        nxt.phase = lzps_pkg::PH_CHAR;
                    end
                end
                lzps_pkg::PH_CHAR:
                begin
                    nxt       = lzps_pkg::STATE_RESET;
                    res.valid = 1'b1;
                end
                default:
                begin
                    nxt = lzps_pkg::STATE_RESET;
                    if (lead_n == lzps_pkg::LEN_STRAY)
                    begin
                        // stray continuation byte: dropped
                    end
                    else if (lead_n == lzps_pkg::LEN_SINGLE)
                    begin
                        nxt.acc   = {14'b0, byte_value[6:0]};
                        nxt.phase = lzps_pkg::PH_CHAR;
                    end
                    else if (lead_n == lzps_pkg::LEN_OVERLONG
                             || lead_n > lzps_pkg::SEQ_LIMIT)
                    begin
                        nxt.phase = lzps_pkg::PH_CHAR;
                    end
                    else
                    begin
                        nxt.expected = lead_n;
                        nxt.seen     = 3'd1;
                        nxt.acc      = lead_acc;
                        nxt.phase    = lzps_pkg::PH_CONT;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/lz78_pair_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz78_pair_stream_parser_unit
// parses a byte stream of (utf-8 coded index, character) pairs into pairs
// ----------------------------------------------------------------------------
// channel  dir  tdata                                     tuser
// s_*      in   [7:0] byte_value                          [0] opcode (1 = eos)
// m_*      out  [20:0] pair_index, [28:21] pair_char      [0] is_terminator
//
// one transaction per cycle while the skid stage is empty: the parse step is a
// single combinational pass from the state register into the output register
// at most one pair leaves per accepted transaction, always from the output register
// a skid register behind the output register keeps s_tready a flop, so a
// stall on m_tready reaches s_tready via the skid valid flop; nothing is lost
// reset clears parse state and both output stages; s_tready rises in the
// cycle after rst_n is released
// ----------------------------------------------------------------------------
module lz78_pair_stream_parser_unit
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] byte_value
    input  wire         s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [20:0] pair_index, [28:21] pair_char, [31:29] zero
    output logic        m_tuser    // [0] is_terminator
);

    lzps_pkg::parse_state_t state_reg;
    lzps_pkg::parse_state_t state_next;
    lzps_pkg::pair_t        step_res;
    lzps_pkg::pair_t        out_reg;
    lzps_pkg::pair_t        skid_reg;
    logic                   run_reg;
    logic                   in_fire;
    logic                   out_free;

    assign in_fire  = s_tvalid & s_tready;
    // main output stage can take a new pair this cycle
    assign out_free = ~out_reg.valid | m_tready;

    lzps_step u_step
    (
        .cur        (state_reg),
        .opcode     (s_tuser),
        .byte_value (s_tdata),
        .nxt        (state_next),
        .res        (step_res)
    );

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzps_pkg::STATE_RESET;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // output register plus skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= 1'b0;
            out_reg.valid  <= 1'b0;
            skid_reg.valid <= 1'b0;
        end
        else
        begin
            run_reg <= 1'b1;
            if (skid_reg.valid)
            begin
                // input is held off while the skid stage is full
                if (m_tready)
                begin
                    out_reg        <= skid_reg;
                    skid_reg.valid <= 1'b0;
                end
            end
            else if (out_free)
            begin
                if (in_fire & step_res.valid)
                begin
                    out_reg <= step_res;
                end
                else
                begin
                    out_reg.valid <= 1'b0;
                end
            end
            else if (in_fire & step_res.valid)
            begin
                skid_reg <= step_res;
            end
        end
    end

    assign s_tready = run_reg & ~skid_reg.valid;
    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {3'b000, out_reg.pchar, out_reg.index};
    assign m_tuser  = out_reg.term;

    // the skid stage only fills behind a stalled output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_reg.valid |-> out_reg.valid)
        else $error("skid stage holds a pair while output register is empty");

    // collecting continuation bytes always has some left to take
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == lzps_pkg::PH_CONT)
            |-> (state_reg.seen < state_reg.expected && state_reg.expected >= 3'd2))
        else $error("continuation phase with no bytes outstanding");

    // end of stream always returns the parser to the lead position
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser == lzps_pkg::OP_EOS)
            |=> (state_reg.phase == lzps_pkg::PH_LEAD && state_reg.acc == '0))
        else $error("parser not cleared after end of stream");

    // a terminator pair carries index zero and the closing character
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser)
            |-> (m_tdata[20:0] == '0 && m_tdata[28:21] == lzps_pkg::END_CHAR))
        else $error("malformed terminator pair");

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for lz78_pair_stream_parser_unit: a table of directed
// byte sequences, then random pair streams with malformed sequences mixed in,
// all checked in order against a cycle-free pair predictor
// ----------------------------------------------------------------------------
module testbench;

    // one decoded pair as it should leave the block
    typedef struct {
        bit          valid;
        logic [20:0] index;
        logic [7:0]  pchar;
        logic        term;
    } decoded_pair_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic          op;
        logic [7:0]    b;
        bit            typed;
        decoded_pair_t want;
    } vec_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] byte_value
    logic        s_tuser;    // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [20:0] pair_index, [28:21] pair_char, [31:29] zero
    logic        m_tuser;    // [0] is_terminator

    // predictor state
    lzps_pkg::phase_t ph;
    logic [2:0]  exp_len;
    logic [2:0]  got_len;
    logic [20:0] acc;

    decoded_pair_t pending_pairs[$];
    vec_row_t      vec_tab[$];
    decoded_pair_t no_pair;

    int errors;
    int fed;
    int xfers;
    int pairs_checked;
    int terms_checked;
    int malformed;
    int burst_left;

    lz78_pair_stream_parser_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void clear_parse();
        ph      = lzps_pkg::PH_LEAD;
        exp_len = 3'd0;
        got_len = 3'd0;
        acc     = '0;
    endfunction

    // advances the predictor by one byte or eos, returns the pair it causes
    function automatic void parse_byte(input logic op, input logic [7:0] b,
                                       output decoded_pair_t res);
        logic [2:0]  n;
        logic [20:0] part;
        res.valid = 1'b0;
        res.index = '0;
        res.pchar = '0;
        res.term  = 1'b0;
        if (op == lzps_pkg::OP_EOS)
        begin
            clear_parse();
            res.valid = 1'b1;
            res.pchar = lzps_pkg::END_CHAR;
            res.term  = 1'b1;
        end
        else
        begin
            case (ph)
                lzps_pkg::PH_CONT:
                begin
                    // a non-continuation byte cuts the index short and is dropped
                    if (b[7:6] != 2'b10 || got_len >= exp_len || exp_len > 3'd4)
                        ph = lzps_pkg::PH_CHAR;
                    else
                    begin
                        got_len = got_len + 3'd1;
                        part    = {15'd0, b[5:0]};
                        acc     = acc | (part << (6 * (exp_len - got_len)));
                        if (got_len == exp_len)
                            ph = lzps_pkg::PH_CHAR;
                    end
                end
                lzps_pkg::PH_CHAR:
                begin
                    res.valid = 1'b1;
                    res.index = acc;
                    res.pchar = b;
                    clear_parse();
                end
                default:
                begin
                    clear_parse();
                    if (b < 8'h80)
                        n = 3'd1;
                    else if (b < 8'hC0)
                        n = 3'd0;
                    else if (b <= 8'hDF)
                        n = 3'd2;
                    else if (b <= 8'hEF)
                        n = 3'd3;
                    else if (b <= 8'hF7)
                        n = 3'd4;
                    else
                        n = 3'd5;
                    if (n == 3'd1)
                    begin
                        acc = {14'd0, b[6:0]};
                        ph  = lzps_pkg::PH_CHAR;
                    end
                    else if (n > lzps_pkg::MAX_SEQ_LEN || n > 3'd4)
                    begin
                        // overlong lead: index 0, next byte is the character
                        acc = '0;
                        ph  = lzps_pkg::PH_CHAR;
                    end
                    else if (n != 3'd0)
                    begin
                        exp_len = n;
                        got_len = 3'd1;
                        part    = {13'd0, b & (8'h7F >> n)};
                        acc     = part << (6 * (n - 1));
                        ph      = lzps_pkg::PH_CONT;
                    end
                    // stray continuation byte leaves the reset state
                end
            endcase
        end
    endfunction

    // offers one transaction, records the expected pair once it is taken,
    // then idles between bursts
    task automatic push_item(input logic op, input logic [7:0] b,
                             input bit typed, input decoded_pair_t want);
        decoded_pair_t p;
        int            gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        xfers++;
        parse_byte(op, b, p);
        if (p.valid)
        begin
            if (typed)
                p = want;
            pending_pairs.push_back(p);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
        end
    endtask

    task automatic push_data(input logic [7:0] b);
        push_item(lzps_pkg::OP_DATA, b, 1'b0, no_pair);
        fed++;
    endtask

    task automatic add_vec(input logic op, input logic [7:0] b, input bit typed,
                           input logic [20:0] idx, input logic [7:0] ch,
                           input logic term);
        vec_row_t r;
        r.op         = op;
        r.b          = b;
        r.typed      = typed;
        r.want.valid = 1'b1;
        r.want.index = idx;
        r.want.pchar = ch;
        r.want.term  = term;
        vec_tab.push_back(r);
    endtask

    // holds the sender off until every expected pair has arrived
    task automatic drain_pairs();
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // lead byte of a well-formed index of len bytes with random payload
    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom);
        return {2'b10, r[5:0]};
    endfunction

    // receiver: ready pattern switches at random between four modes
    initial
    begin : rx_pattern
        int mode;
        int mode_left;
        int hold;
        int cyc;
        bit level;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        cyc       = 0;
        level     = 1'b1;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2:
                begin
                    if (hold == 0)
                    begin
                        level = ~level;
                        hold  = level ? $urandom_range(1, 20) : $urandom_range(1, 30);
                    end
                    hold--;
                    m_tready <= level;
                end
                default: m_tready <= (cyc % 3 != 0);
            endcase
        end
    end

    // result checker: in-order compare against the oldest expected pair
    always @(posedge clk)
    begin : pair_check
        decoded_pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pairs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pair, actual index=%0h char=%0h term=%0b",
                         $time, m_tdata[20:0], m_tdata[28:21], m_tuser);
            end
            else
            begin
                want = pending_pairs.pop_front();
                pairs_checked++;
                if (want.term)
                    terms_checked++;
                if (m_tdata[20:0] !== want.index)
                begin
                    errors++;
                    $display("%0t: pair_index expected %0h actual %0h",
                             $time, want.index, m_tdata[20:0]);
                end
                if (m_tdata[28:21] !== want.pchar)
                begin
                    errors++;
                    $display("%0t: pair_char expected %0h actual %0h",
                             $time, want.pchar, m_tdata[28:21]);
                end
                if (m_tuser !== want.term)
                begin
                    errors++;
                    $display("%0t: is_terminator expected %0b actual %0b",
                             $time, want.term, m_tuser);
                end
                if (m_tdata[31:29] !== 3'b000)
                begin
                    errors++;
                    $display("%0t: tdata pad expected 0 actual %0b",
                             $time, m_tdata[31:29]);
                end
            end
        end
    end

    initial
    begin : stimulus
        int         kind;
        int         len;
        int         k;
        bit         mid_drained;
        logic [7:0] b;
        errors        = 0;
        fed           = 0;
        xfers         = 0;
        pairs_checked = 0;
        terms_checked = 0;
        malformed     = 0;
        mid_drained   = 1'b0;
        burst_left    = $urandom_range(1, 40);
        no_pair       = '{valid: 1'b0, index: '0, pchar: '0, term: 1'b0};
        clear_parse();

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= lzps_pkg::OP_DATA;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, stray, overlong, truncation, eos mid-pair and idle
        add_vec(lzps_pkg::OP_DATA, 8'h7F, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hFF, 1, 21'h7F, 8'hFF, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h80, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hF8, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h00, 1, 21'h0, 8'h00, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hFF, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h55, 1, 21'h0, 8'h55, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hC0, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h80, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h31, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hF7, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hBF, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hBF, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hBF, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h01, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hE1, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h41, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h62, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hF0, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h90, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_EOS,  8'h00, 1, 21'h0, lzps_pkg::END_CHAR, 1);
        add_vec(lzps_pkg::OP_EOS,  8'hA5, 1, 21'h0, lzps_pkg::END_CHAR, 1);
        add_vec(lzps_pkg::OP_DATA, 8'hDF, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'hBF, 0, 0, 0, 0);
        add_vec(lzps_pkg::OP_DATA, 8'h20, 0, 0, 0, 0);
        foreach (vec_tab[i])
            push_item(vec_tab[i].op, vec_tab[i].b, vec_tab[i].typed, vec_tab[i].want);

        drain_pairs();

        // random: mostly well-formed pairs, the rest malformed or noise
        while (fed < 1900)
        begin
            if (!mid_drained && fed >= 950)
            begin
                drain_pairs();
                mid_drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                len = $urandom_range(1, 4);
                push_data(lead_byte(len));
                for (k = 1; k < len; k++)
                    push_data(cont_byte());
                push_data(8'($urandom));
            end
            else if (kind < 78)
            begin
                // sequence cut short by a non-continuation byte
                malformed++;
                len = $urandom_range(2, 4);
                push_data(lead_byte(len));
                for (k = $urandom_range(0, len - 2); k > 0; k--)
                    push_data(cont_byte());
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                push_data(b);
                push_data(8'($urandom));
            end
            else if (kind < 84)
            begin
                // stray continuation bytes, not counted in fed
                malformed++;
                for (k = $urandom_range(1, 3); k > 0; k--)
                    push_item(lzps_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'hBF)),
                              1'b0, no_pair);
            end
            else if (kind < 89)
            begin
                malformed++;
                push_data(8'($urandom_range(8'hF8, 8'hFF)));
                push_data(8'($urandom));
            end
            else if (kind < 94)
            begin
                // eos after a partial pair of random depth
                malformed++;
                len = $urandom_range(1, 4);
                k   = $urandom_range(0, len);
                if (k > 0)
                    push_data(lead_byte(len));
                for (int j = 1; j < k; j++)
                    push_data(cont_byte());
                push_item(lzps_pkg::OP_EOS, 8'($urandom), 1'b0, no_pair);
                fed++;
            end
            else
                push_data(8'($urandom));
        end

        drain_pairs();

        $display("covered %0d transactions in, %0d pairs checked (%0d terminators)",
                 xfers, pairs_checked, terms_checked);
        $display("malformed sequences injected: %0d (stray, overlong, truncated, early eos)",
                 malformed);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hdl/lzps_pkg.sv
hdl/lzps_step.sv
hdl/lz78_pair_stream_parser_unit.sv
sim/testbench.sv
